// ----- rtl/rgf_pkg.sv -----
// row gap fill package: widths, constants and the result item type
// shared by the core, the top level and the port checker; no dependencies
package rgf_pkg;

  // row bound and compared sample width
  localparam int ROW_MAX     = 4096;
  localparam int SAMPLE_BITS = 16;

  // port field widths
  localparam int VALUE_W = 16;
  localparam int LEN_W   = 13;

  // internal counter width, wide enough to hold ROW_MAX itself
  localparam int RUN_W = $clog2(ROW_MAX + 1);

  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(ROW_MAX);

  // low SAMPLE_BITS bits of a sample take part in the compare
  localparam logic [VALUE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // number of results one sample can cause
  localparam logic [1:0] N_NONE = 2'd0;
  localparam logic [1:0] N_ONE  = 2'd1;
  localparam logic [1:0] N_TWO  = 2'd2;

  // one run-length result item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
    logic               last;
    logic [LEN_W-1:0]   fill_count;
  } result_t;

  // results caused by the sample held at the core input
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

// ----- rtl/rgf_core.sv -----
// row gap fill core: row state and the per-sample run decision
// depends on rgf_pkg
module rgf_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rgf_pkg::VALUE_W-1:0] sample,
  input  logic                        last_in_row,
  input  logic [rgf_pkg::LEN_W-1:0]   max_gap,
  input  logic                        fire,
  output rgf_pkg::result_pair_t       results
);
  import rgf_pkg::*;

  // row state
  logic [VALUE_W-1:0] bound_value;
  logic               seen_nonzero;
  logic [RUN_W-1:0]   zero_run;
  logic [RUN_W-1:0]   filled_so_far;

  logic [VALUE_W-1:0] s;
  logic               is_zero;
  logic               fill_ok;
  logic [RUN_W-1:0]   zero_run_inc;
  logic [RUN_W:0]     fill_sum;
  logic [RUN_W-1:0]   fill_sat;
  logic [RUN_W-1:0]   filled_next;
  logic [VALUE_W-1:0] gap_value;

  // sample decode and gap decision
  always_comb begin
    s            = sample & SAMPLE_MASK;
    is_zero      = (s == '0);
    zero_run_inc = (zero_run < RUN_MAX) ? zero_run + RUN_W'(1) : zero_run;
    fill_ok      = seen_nonzero && (s == bound_value)
                   && ({{(RUN_W+LEN_W){1'b0}}, zero_run} <= {{(RUN_W+LEN_W){1'b0}}, max_gap});
    fill_sum     = {1'b0, filled_so_far} + {1'b0, zero_run};
    fill_sat     = (fill_sum > {1'b0, RUN_MAX}) ? RUN_MAX : fill_sum[RUN_W-1:0];
    filled_next  = fill_ok ? fill_sat : filled_so_far;
    gap_value    = fill_ok ? bound_value : '0;
  end

  // result items for the held sample
  always_comb begin
    results = '0;
    if (is_zero) begin
      results.count            = last_in_row ? N_ONE : N_NONE;
      results.first.value      = '0;
      results.first.length     = LEN_W'(zero_run_inc);
      results.first.last       = last_in_row;
      results.first.fill_count = last_in_row ? LEN_W'(filled_so_far) : '0;
    end else if (zero_run != '0) begin
      results.count             = N_TWO;
      results.first.value       = gap_value;
      results.first.length      = LEN_W'(zero_run);
      results.second.value      = s;
      results.second.length     = LEN_W'(1);
      results.second.last       = last_in_row;
      results.second.fill_count = last_in_row ? LEN_W'(filled_next) : '0;
    end else begin
      results.count            = N_ONE;
      results.first.value      = s;
      results.first.length     = LEN_W'(1);
      results.first.last       = last_in_row;
      results.first.fill_count = last_in_row ? LEN_W'(filled_so_far) : '0;
    end
  end

  // state update when the sample is taken; end of row clears the row
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_value   <= '0;
      seen_nonzero  <= 1'b0;
      zero_run      <= '0;
      filled_so_far <= '0;
    end else if (fire) begin
      if (last_in_row) begin
        bound_value   <= '0;
        seen_nonzero  <= 1'b0;
        zero_run      <= '0;
        filled_so_far <= '0;
      end else if (is_zero) begin
        zero_run <= zero_run_inc;
      end else begin
        bound_value   <= s;
        seen_nonzero  <= 1'b1;
        zero_run      <= '0;
        filled_so_far <= filled_next;
      end
    end
  end

endmodule

// ----- rtl/row_gap_fill.sv -----
// row gap fill top level: input register, core and two-slot result queue
// depends on rgf_pkg and rgf_core
//
// usage
//   input channel in_valid/in_ready carries sample and last_in_row, one row
//   in order with last_in_row on its final sample
//   output channel out_valid/out_ready carries run-length items run_value,
//   run_length, last_of_row and row_fill_count; the final item of a row has
//   last_of_row set and the row's filled sample count
//   configuration channel cfg_valid/cfg_ready writes max_gap from cfg_data;
//   cfg_ready is always high, write only while the block is idle
// a sample waits in the input register; its results then enter the result queue
// throughput: one sample per cycle while the receiver takes every result; a
//   sample that ends a zero run gives two results, and as the result queue
//   drains one item per cycle, such a sample holds the input back until it empties
// zero samples inside a row give no result until their run is closed
// reset: rst clears the row state, empties the input register and the result
//   queue and sets max_gap to 1
// receiver stall: results wait in the two-slot queue, then the input register
//   fills and in_ready drops
module row_gap_fill (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rgf_pkg::VALUE_W-1:0] sample,
  input  logic                        last_in_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgf_pkg::VALUE_W-1:0] run_value,
  output logic [rgf_pkg::LEN_W-1:0]   run_length,
  output logic                        last_of_row,
  output logic [rgf_pkg::LEN_W-1:0]   row_fill_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rgf_pkg::LEN_W-1:0]   cfg_data
);
  import rgf_pkg::*;

  logic [LEN_W-1:0]   max_gap;
  logic               in_full;
  logic [VALUE_W-1:0] sample_r;
  logic               last_r;
  result_t            slot0;
  result_t            slot1;
  logic [1:0]         slot_cnt;
  logic [1:0]         slot_cnt_next;
  result_t            slot0_next;
  result_t            slot1_next;
  result_pair_t       results;
  logic               pop;
  logic               fire;
  logic [1:0]         cnt_keep;
  logic [2:0]         cnt_need;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      max_gap <= cfg_data;
    end
  end

  // handshake control
  always_comb begin
    pop      = out_valid && out_ready;
    cnt_keep = slot_cnt - {1'b0, pop};
    cnt_need = {1'b0, cnt_keep} + {1'b0, results.count};
    fire     = in_full && (cnt_need <= 3'd2);
    in_ready = !in_full || fire;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= sample;
      last_r   <= last_in_row;
    end
  end

  rgf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_r),
    .last_in_row(last_r),
    .max_gap    (max_gap),
    .fire       (fire),
    .results    (results)
  );

  // result queue: shift on transaction, append new results behind kept ones
  always_comb begin
    slot0_next    = pop ? slot1 : slot0;
    slot1_next    = slot1;
    slot_cnt_next = cnt_keep;
    if (fire) begin
      slot_cnt_next = cnt_need[1:0];
      if (cnt_keep == 2'd0) begin
        slot0_next = results.first;
        slot1_next = results.second;
      end else if (cnt_keep == 2'd1) begin
        slot1_next = results.first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= 2'd0;
    end else begin
      slot_cnt <= slot_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  // output ports
  assign out_valid      = (slot_cnt != 2'd0);
  assign run_value      = slot0.value;
  assign run_length     = slot0.length;
  assign last_of_row    = slot0.last;
  assign row_fill_count = slot0.fill_count;

endmodule

// ----- rtl/rgf_checker.sv -----
// row gap fill port checker and its bind to the top level
// depends on rgf_pkg and row_gap_fill
module rgf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rgf_pkg::VALUE_W-1:0] run_value,
  input logic [rgf_pkg::LEN_W-1:0]   run_length,
  input logic                        last_of_row,
  input logic [rgf_pkg::LEN_W-1:0]   row_fill_count
);
  import rgf_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(run_value) && $stable(run_length)
      && $stable(last_of_row) && $stable(row_fill_count))
    else $error("result changed while stalled");

  // run length is never zero and never exceeds the row bound
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length != '0 && run_length <= LEN_W'(ROW_MAX))
    else $error("run length out of range");

  // fill count only on the final result of a row
  a_fill_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_row |-> row_fill_count == '0)
    else $error("fill count outside end of row");

  // nothing offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind row_gap_fill rgf_checker u_rgf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .run_value     (run_value),
  .run_length    (run_length),
  .last_of_row   (last_of_row),
  .row_fill_count(row_fill_count)
);
